// ----- hw/rtl/vvs_pkg.sv -----
// Shared types and constants of the velocity Verlet step block.
package vvs_pkg;

   localparam int NUM_AXES = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP     = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_DAMPING = 4'd1;

   localparam logic [15:0] TIME_STEP_RESET     = 16'd655;
   localparam logic [15:0] ACCEL_DAMPING_RESET = 16'd16384;

   typedef enum logic {
      OP_PREDICT = 1'b0,
      OP_CORRECT = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic        [31:0] inv_mass;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic signed [31:0] other_x;
      logic signed [31:0] other_y;
      logic signed [31:0] other_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic               saturated;
   } rsp_word_type;

endpackage

// ----- hw/rtl/vvs_coef.sv -----
// Shared correct-step gain pipeline: damping times time step times inverse mass.
module vvs_coef (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] in_inv_mass,
   input  logic [15:0] time_step,
   input  logic [15:0] accel_damping,
   output logic [32:0] gain
);

   logic [31:0] cd_ff;
   logic [31:0] cd_in;
   logic [31:0] im1_ff;
   logic [48:0] gp_ff;
   logic [48:0] gp_in;
   logic [32:0] g_ff;

   assign cd_in = accel_damping * time_step;
   assign gp_in = cd_ff[31:15] * im1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         cd_ff  <= cd_in;
         im1_ff <= in_inv_mass;
         gp_ff  <= gp_in;
         g_ff   <= gp_ff[48:16];
      end
   end

   assign gain = g_ff;

endmodule

// ----- hw/rtl/vvs_lane.sv -----
// One axis lane: predict position or correct velocity, then saturate.
module vvs_lane (
   input  logic               clock,
   input  logic               enable,
   input  vvs_pkg::opcode_type in_opcode,
   input  logic        [31:0] in_inv_mass,
   input  logic signed [31:0] in_vel,
   input  logic signed [31:0] in_force,
   input  logic signed [31:0] in_other,
   input  logic        [15:0] time_step,
   input  logic        [32:0] gain,
   output logic signed [31:0] out_value,
   output logic               out_sat
);

   logic signed [32:0] im_s;
   logic signed [16:0] dt_s;
   logic signed [33:0] g_s;

   logic signed [64:0] fm_full;
   logic signed [63:0] fm_ff;
   logic signed [31:0] vel1_ff;
   logic signed [32:0] sum_in;
   logic signed [32:0] sum1_ff;
   logic signed [31:0] base_in;
   logic signed [31:0] base1_ff;
   logic               corr1_ff;

   logic signed [47:0] a_s;
   logic signed [64:0] ah_full;
   logic signed [63:0] ah_ff;
   logic signed [31:0] vel2_ff;
   logic signed [32:0] sum2_ff;
   logic signed [31:0] base2_ff;
   logic               corr2_ff;

   logic signed [46:0] h_s;
   logic signed [47:0] s_in;
   logic signed [47:0] s_ff;
   logic signed [32:0] sum3_ff;
   logic signed [31:0] base3_ff;
   logic               corr3_ff;

   logic signed [64:0] sd_full;
   logic signed [66:0] sg_full;
   logic signed [50:0] d_pred;
   logic signed [50:0] d_corr;
   logic signed [50:0] d_in;
   logic signed [50:0] d_ff;
   logic signed [31:0] base4_ff;

   logic signed [51:0] total;
   logic signed [31:0] value_in;
   logic               sat_in;
   logic signed [31:0] value_ff;
   logic               sat_ff;

   assign im_s = {1'b0, in_inv_mass};
   assign dt_s = {1'b0, time_step};
   assign g_s  = {1'b0, gain};

   assign fm_full = in_force * im_s;
   assign sum_in  = in_other + in_force;
   assign base_in = (in_opcode == vvs_pkg::OP_CORRECT) ? in_vel : in_other;

   assign a_s     = $signed(fm_ff[63:16]);
   assign ah_full = a_s * dt_s;

   assign h_s  = $signed(ah_ff[63:17]);
   assign s_in = vel2_ff + h_s;

   assign sd_full = s_ff * dt_s;
   assign sg_full = sum3_ff * g_s;
   assign d_pred  = $signed(sd_full[64:16]);
   assign d_corr  = $signed(sg_full[66:16]);
   assign d_in    = corr3_ff ? d_corr : d_pred;

   assign total = base4_ff + d_ff;

   always_comb begin
      value_in = total[31:0];
      sat_in   = 1'b0;
      if (total[51:31] != {21{total[51]}}) begin
         sat_in   = 1'b1;
         value_in = total[51] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fm_ff    <= fm_full[63:0];
         vel1_ff  <= in_vel;
         sum1_ff  <= sum_in;
         base1_ff <= base_in;
         corr1_ff <= (in_opcode == vvs_pkg::OP_CORRECT);

         ah_ff    <= ah_full[63:0];
         vel2_ff  <= vel1_ff;
         sum2_ff  <= sum1_ff;
         base2_ff <= base1_ff;
         corr2_ff <= corr1_ff;

         s_ff     <= s_in;
         sum3_ff  <= sum2_ff;
         base3_ff <= base2_ff;
         corr3_ff <= corr2_ff;

         d_ff     <= d_in;
         base4_ff <= base3_ff;

         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_value = value_ff;
   assign out_sat   = sat_ff;

endmodule

// ----- hw/rtl/vvs_merge.sv -----
// Merge of the lane results into one word, with output register and skid stage.
module vvs_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [31:0]    lane_value [vvs_pkg::NUM_AXES],
   input  logic                  lane_sat   [vvs_pkg::NUM_AXES],
   output logic                  skid_full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vvs_pkg::rsp_word_type rsp_word
);

   vvs_pkg::rsp_word_type merged;
   vvs_pkg::rsp_word_type out_ff;
   vvs_pkg::rsp_word_type skid_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  skid_full_ff;
   logic                  skid_full_in;
   logic                  out_load;
   logic                  out_from_skid;
   logic                  skid_load;
   logic                  out_taken;

   assign merged.new_x     = lane_value[0];
   assign merged.new_y     = lane_value[1];
   assign merged.new_z     = lane_value[2];
   assign merged.saturated = lane_sat[0] | lane_sat[1] | lane_sat[2];

   assign out_taken = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_full_in  = skid_full_ff;
      out_load      = 1'b0;
      out_from_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_full_ff) begin
         if (out_taken) begin
            out_load      = 1'b1;
            out_from_skid = 1'b1;
            skid_full_in  = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || !rsp_stall) begin
            out_load     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load    = 1'b1;
            skid_full_in = 1'b1;
         end
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_from_skid ? skid_ff : merged;
      end
      if (skid_load) begin
         skid_ff <= merged;
      end
   end

   assign skid_full = skid_full_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

// ----- hw/rtl/velocity_verlet_step_top.sv -----
// Top level of the velocity Verlet step block.
// One atom word enters and one result word leaves per cycle while the
// output is not stalled; three axis lanes run side by side, each a
// five-stage chain with a multiply in its first, second and fourth stages,
// and a shared three-stage gain pipeline feeds the correct step. When the
// downstream side stalls, one word parks in a skid stage and req_stall
// rises until it drains.
// Write time_step and accel_damping only while no word is in flight.
module velocity_verlet_step_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  vvs_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output vvs_pkg::rsp_word_type                  rsp_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vvs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [vvs_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int LANE_DEPTH = 5;

   logic [15:0]           time_step_ff;
   logic [15:0]           accel_damping_ff;
   logic [LANE_DEPTH-1:0] valid_ff;
   logic                  enable;
   logic                  skid_full;
   logic [32:0]           gain;

   logic signed [31:0] vel        [vvs_pkg::NUM_AXES];
   logic signed [31:0] force_in   [vvs_pkg::NUM_AXES];
   logic signed [31:0] other      [vvs_pkg::NUM_AXES];
   logic signed [31:0] lane_value [vvs_pkg::NUM_AXES];
   logic               lane_sat   [vvs_pkg::NUM_AXES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff     <= vvs_pkg::TIME_STEP_RESET;
         accel_damping_ff <= vvs_pkg::ACCEL_DAMPING_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vvs_pkg::CSR_TIME_STEP: begin
               time_step_ff <= csr_data;
            end
            vvs_pkg::CSR_ACCEL_DAMPING: begin
               accel_damping_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // advance the whole pipeline unless the skid stage holds a word
   assign enable    = ~skid_full;
   assign req_stall = skid_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[LANE_DEPTH-2:0], req_valid};
      end
   end

   assign vel[0]      = req_word.vel_x;
   assign vel[1]      = req_word.vel_y;
   assign vel[2]      = req_word.vel_z;
   assign force_in[0] = req_word.force_x;
   assign force_in[1] = req_word.force_y;
   assign force_in[2] = req_word.force_z;
   assign other[0]    = req_word.other_x;
   assign other[1]    = req_word.other_y;
   assign other[2]    = req_word.other_z;

   vvs_coef u_coef (
      .clock         (clock),
      .enable        (enable),
      .in_inv_mass   (req_word.inv_mass),
      .time_step     (time_step_ff),
      .accel_damping (accel_damping_ff),
      .gain          (gain)
   );

   for (genvar i = 0; i < vvs_pkg::NUM_AXES; i++) begin : g_lane
      vvs_lane u_lane (
         .clock       (clock),
         .enable      (enable),
         .in_opcode   (req_word.opcode),
         .in_inv_mass (req_word.inv_mass),
         .in_vel      (vel[i]),
         .in_force    (force_in[i]),
         .in_other    (other[i]),
         .time_step   (time_step_ff),
         .gain        (gain),
         .out_value   (lane_value[i]),
         .out_sat     (lane_sat[i])
      );
   end

   vvs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_ff[LANE_DEPTH-1] & enable),
      .lane_value (lane_value),
      .lane_sat   (lane_sat),
      .skid_full  (skid_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule
